@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each macro expands to a labeled concurrent assertion in simulation
// and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LFYS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define LFYS_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define LFYS_ASSERT(label, clk, rst, prop, msg)
`define LFYS_ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

@@ rtl/lfys_pkg.sv @@
`default_nettype none

package lfys_pkg;

   // Table geometry
   localparam int ADDR_W = 10;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int DATA_W = 16;
   localparam int LEN_W  = ADDR_W + 1;

   // Generator
   localparam int          SEED_W  = 32;
   localparam int          MUL_W   = 21;
   localparam logic [MUL_W-1:0]  LCG_MUL = 21'd1664525;
   localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

   // Remainder unit: one dividend bit per cycle
   localparam int CNT_W = $clog2(SEED_W);

   // Item modes
   localparam int MODE_W = 2;
   localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SHUFFLE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

   // Generator control
   typedef struct packed {
      logic              load;
      logic              step;
      logic [SEED_W-1:0] seed;
   } lcg_req_type;

   // Remainder unit control
   typedef struct packed {
      logic              start;
      logic [SEED_W-1:0] dividend;
      logic [LEN_W-1:0]  divisor;
   } div_req_type;

endpackage

`default_nettype wire

@@ rtl/lfys_ram.sv @@
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module lfys_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds when no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/lfys_lcg.sv @@
`default_nettype none

// 32-bit LCG: g = g * MUL + ADD. Multiply and add sit in separate cycles.
module lfys_lcg (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lfys_pkg::lcg_req_type       req,
   output logic                             done,
   output logic [lfys_pkg::SEED_W-1:0]      value
);

   import lfys_pkg::*;

   localparam int PROD_W = SEED_W + MUL_W;

   logic [SEED_W-1:0] gen_ff;
   logic [SEED_W-1:0] mul_ff;
   logic              add_ff;
   logic              done_ff;
   logic [PROD_W-1:0] prod;

   assign prod = PROD_W'(gen_ff) * PROD_W'(LCG_MUL);

   // product stage, low word only
   always_ff @(posedge clock) begin
      if (req.step) begin
         mul_ff <= prod[SEED_W-1:0];
      end
   end

   // generator state and add stage
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= '0;
         add_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         add_ff  <= req.step;
         if (req.load) begin
            gen_ff <= req.seed;
         end else if (add_ff) begin
            gen_ff  <= mul_ff + LCG_ADD;
            done_ff <= 1'b1;
         end
      end
   end

   assign done  = done_ff;
   assign value = gen_ff;

endmodule

`default_nettype wire

@@ rtl/lfys_div.sv @@
`default_nettype none
`include "assert_macros.svh"

// Bit-serial restoring remainder: dividend mod divisor
module lfys_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lfys_pkg::div_req_type       req,
   output logic                             done,
   output logic [lfys_pkg::ADDR_W-1:0]      remainder
);

   import lfys_pkg::*;

   logic [SEED_W-1:0] dvd_ff;
   logic [LEN_W-1:0]  dsr_ff;
   logic [ADDR_W-1:0] rem_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [LEN_W-1:0]  shifted;
   logic [LEN_W-1:0]  diff;
   logic              fits;

   // shift in next dividend bit, subtract if divisor fits
   assign shifted = {rem_ff, dvd_ff[SEED_W-1]};
   assign fits    = (shifted >= dsr_ff);
   assign diff    = shifted - dsr_ff;

   always_ff @(posedge clock) begin
      if (req.start) begin
         dvd_ff <= req.dividend;
         dsr_ff <= req.divisor;
         rem_ff <= '0;
         cnt_ff <= CNT_W'(SEED_W - 1);
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[SEED_W-2:0], 1'b0};
         rem_ff <= fits ? diff[ADDR_W-1:0] : shifted[ADDR_W-1:0];
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   `LFYS_ASSERT_NEVER(a_div_restart, clock, reset, req.start && busy_ff, "divider restarted while busy")
   `LFYS_ASSERT_NEVER(a_div_rem_range, clock, reset, done_ff && ({1'b0, rem_ff} >= dsr_ff), "remainder not below divisor")

endmodule

`default_nettype wire

@@ rtl/lcg_fisher_yates_shuffle.sv @@
// Write and unknown-mode items load their result on acceptance; reads first go through
//   the registered RAM read and S_READ.
// Shuffle over n = min(length, 1024) entries: for n < 2 the result loads on acceptance, else
//   n - 1 swaps run S_STEP, S_GEN, S_DIV (bit-serial remainder unit), S_RDJ, S_WRI, S_WRJ.
// One item in flight: the next request transfer can share the edge of the result transfer.
// Reset (synchronous, active high) clears control, generator and length; table undefined.
`default_nettype none
`include "assert_macros.svh"

module lcg_fisher_yates_shuffle (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration
   input  wire logic                          csr_write_enable,
   input  wire logic [lfys_pkg::LEN_W-1:0]    csr_write_data,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [lfys_pkg::MODE_W-1:0]   req_mode,
   input  wire logic [lfys_pkg::ADDR_W-1:0]   req_position,
   input  wire logic [lfys_pkg::DATA_W-1:0]   req_value,
   input  wire logic [lfys_pkg::SEED_W-1:0]   req_seed,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [lfys_pkg::DATA_W-1:0]   rsp_data,
   output logic      [lfys_pkg::MODE_W-1:0]   rsp_completed
);

   import lfys_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_READ = 9'b000000010,
      S_STEP = 9'b000000100,
      S_GEN  = 9'b000001000,
      S_DIV  = 9'b000010000,
      S_RDJ  = 9'b000100000,
      S_WRI  = 9'b001000000,
      S_WRJ  = 9'b010000000,
      S_FIN  = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  length_ff;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [DATA_W-1:0] ei_ff, ei_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [MODE_W-1:0] rsp_completed_ff, rsp_completed_in;

   logic              slot_free;
   logic              req_xfer;
   logic              rsp_load;
   logic [LEN_W-1:0]  len_sat;
   logic [LEN_W-1:0]  len_m1;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   lcg_req_type       lcg_req;
   logic              lcg_done;
   logic [SEED_W-1:0] lcg_value;
   div_req_type       div_req;
   logic              div_done;
   logic [ADDR_W-1:0] div_rem;

   lfys_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lfys_lcg u_lcg (
      .clock (clock),
      .reset (reset),
      .req   (lcg_req),
      .done  (lcg_done),
      .value (lcg_value)
   );

   lfys_div u_div (
      .clock     (clock),
      .reset     (reset),
      .req       (div_req),
      .done      (div_done),
      .remainder (div_rem)
   );

   // length register
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else if (csr_write_enable) begin
         length_ff <= csr_write_data;
      end
   end

   // shuffle span, saturated to the table size
   assign len_sat = (length_ff > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : length_ff;
   assign len_m1  = len_sat - LEN_W'(1);

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && slot_free;
   assign req_xfer  = req_valid && req_ready;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      i_in             = i_ff;
      j_in             = j_ff;
      ei_in            = ei_ff;
      rsp_load         = 1'b0;
      rsp_data_in      = rsp_data_ff;
      rsp_completed_in = rsp_completed_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = i_ff;
      ram_wr_data      = ram_rd_data;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = i_ff;
      lcg_req.load     = 1'b0;
      lcg_req.step     = 1'b0;
      lcg_req.seed     = req_seed;
      div_req.start    = 1'b0;
      div_req.dividend = lcg_value;
      div_req.divisor  = LEN_W'({1'b0, i_ff}) + LEN_W'(1);

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_mode)
                  MODE_WRITE: begin
                     ram_wr_en        = 1'b1;
                     ram_wr_addr      = req_position;
                     ram_wr_data      = req_value;
                     rsp_load         = 1'b1;
                     rsp_data_in      = '0;
                     rsp_completed_in = MODE_WRITE;
                  end
                  MODE_SHUFFLE: begin
                     lcg_req.load = 1'b1;
                     if (len_sat < LEN_W'(2)) begin
                        rsp_load         = 1'b1;
                        rsp_data_in      = '0;
                        rsp_completed_in = MODE_SHUFFLE;
                     end else begin
                        i_in     = len_m1[ADDR_W-1:0];
                        state_in = S_STEP;
                     end
                  end
                  MODE_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_position;
                     state_in    = S_READ;
                  end
                  default: begin
                     rsp_load         = 1'b1;
                     rsp_data_in      = '0;
                     rsp_completed_in = req_mode;
                  end
               endcase
            end
         end
         S_READ: begin
            if (slot_free) begin
               rsp_load         = 1'b1;
               rsp_data_in      = ram_rd_data;
               rsp_completed_in = MODE_READ;
               state_in         = S_IDLE;
            end
         end
         S_STEP: begin
            lcg_req.step = 1'b1;
            state_in     = S_GEN;
         end
         S_GEN: begin
            if (lcg_done) begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            // remainder ready: fetch entry i
            if (div_done) begin
               j_in      = div_rem;
               ram_rd_en = 1'b1;
               state_in  = S_RDJ;
            end
         end
         S_RDJ: begin
            // hold entry i, fetch entry j
            ei_in       = ram_rd_data;
            ram_rd_en   = 1'b1;
            ram_rd_addr = j_ff;
            state_in    = S_WRI;
         end
         S_WRI: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = i_ff;
            ram_wr_data = ram_rd_data;
            state_in    = S_WRJ;
         end
         S_WRJ: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = j_ff;
            ram_wr_data = ei_ff;
            if (i_ff == ADDR_W'(1)) begin
               state_in = S_FIN;
            end else begin
               i_in     = i_ff - ADDR_W'(1);
               state_in = S_STEP;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_load         = 1'b1;
               rsp_data_in      = '0;
               rsp_completed_in = MODE_SHUFFLE;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff             <= i_in;
      j_ff             <= j_in;
      ei_ff            <= ei_in;
      rsp_data_ff      <= rsp_data_in;
      rsp_completed_ff <= rsp_completed_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;
   assign rsp_completed = rsp_completed_ff;

   `LFYS_ASSERT_NEVER(a_rsp_overwrite, clock, reset, rsp_load && rsp_valid_ff && !rsp_ready, "result overwritten before transfer")
   `LFYS_ASSERT_NEVER(a_swap_order, clock, reset, (state_ff == S_WRI || state_ff == S_WRJ) && (j_ff > i_ff), "swap partner above index")
   `LFYS_ASSERT_NEVER(a_index_zero, clock, reset, (state_ff == S_STEP || state_ff == S_GEN || state_ff == S_DIV) && (i_ff == '0), "shuffle step at index zero")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import lfys_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;
   localparam logic [SEED_W-1:0] MUL_FULL     = {{(SEED_W - MUL_W){1'b0}}, LCG_MUL};
   localparam int                QUIET_LIMIT  = 250000;
   localparam int                HOLD_CYCLES  = 200;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] position;
      logic [DATA_W-1:0] value;
      logic [SEED_W-1:0] seed;
   } request_type;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [MODE_W-1:0] completed;
   } response_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic [LEN_W-1:0]  csr_write_data   = '0;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic [MODE_W-1:0] req_mode         = '0;
   logic [ADDR_W-1:0] req_position     = '0;
   logic [DATA_W-1:0] req_value        = '0;
   logic [SEED_W-1:0] req_seed         = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [DATA_W-1:0] rsp_data;
   logic [MODE_W-1:0] rsp_completed;

   // Two copies of the entry store: [0] follows accepted transfers,
   // [1] follows the stimulus as it is planned. The top bit marks a written entry.
   logic [DATA_W:0]   entry_copy [2][DEPTH];
   logic [LEN_W-1:0]  length_now;
   logic [LEN_W-1:0]  plan_length;

   request_type  stim_queue[$];
   response_type response_queue[$];
   request_type  offer;
   int        fail_count   = 0;
   int        results_seen = 0;
   int        send_gap     = 0;
   bit        send_burst   = 1'b0;
   int        ready_wait   = 0;
   bit        take_burst   = 1'b0;
   int        quiet_cycles = 0;

   lcg_fisher_yates_shuffle DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_position     (req_position),
      .req_value        (req_value),
      .req_seed         (req_seed),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .rsp_completed    (rsp_completed)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Fisher-Yates pass over the first len entries of one copy; returns the last generator value
   function automatic logic [SEED_W-1:0] shuffle_copy(input bit which,
                                                      input logic [LEN_W-1:0] len,
                                                      input logic [SEED_W-1:0] seed);
      logic [LEN_W-1:0]  n;
      logic [ADDR_W-1:0] k;
      logic [ADDR_W-1:0] pick;
      logic [SEED_W-1:0] gen;
      logic [DATA_W:0]   held;
      n   = (len > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : len;
      gen = seed;
      if (n >= LEN_W'(2)) begin
         for (k = ADDR_W'(n - LEN_W'(1)); k != '0; k--) begin
            gen  = gen * MUL_FULL + LCG_ADD;
            pick = ADDR_W'(gen % (SEED_W'(k) + SEED_W'(1)));
            held = entry_copy[which][k];
            entry_copy[which][k] = entry_copy[which][pick];
            entry_copy[which][pick] = held;
         end
      end
      return gen;
   endfunction

   // Expected response for one accepted request
   function automatic void predict_response(input request_type item);
      response_type resp;
      resp.data      = '0;
      resp.completed = item.mode;
      case (item.mode)
         MODE_WRITE:   entry_copy[1'b0][item.position] = {1'b1, item.value};
         MODE_SHUFFLE: void'(shuffle_copy(1'b0, length_now, item.seed));
         MODE_READ:    resp.data = entry_copy[1'b0][item.position][DATA_W-1:0];
         default:      ;
      endcase
      response_queue.push_back(resp);
   endfunction

   // Queue a request and track which entries will hold written words
   task automatic plan_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] position,
                            input logic [DATA_W-1:0] value, input logic [SEED_W-1:0] seed);
      request_type item;
      item.mode     = mode;
      item.position = position;
      item.value    = value;
      item.seed     = seed;
      if (mode == MODE_WRITE)
         entry_copy[1'b1][position] = {1'b1, value};
      else if (mode == MODE_SHUFFLE)
         void'(shuffle_copy(1'b1, plan_length, seed));
      stim_queue.push_back(item);
   endtask

   // Find a written entry, half the time starting inside the shuffled range
   function automatic bit pick_written(input int unsigned span, output logic [ADDR_W-1:0] found);
      int unsigned start;
      found = '0;
      if (span > 0 && $urandom_range(0, 1) == 0)
         start = $urandom_range(0, span - 1);
      else
         start = $urandom_range(0, DEPTH - 1);
      for (int unsigned step = 0; step < DEPTH; step++) begin
         found = ADDR_W'((start + step) % DEPTH);
         if (entry_copy[1'b1][found][DATA_W]) begin
            return 1'b1;
         end
      end
      found = '0;
      return 1'b0;
   endfunction

   task automatic wait_drained();
      do
         @(negedge clock);
      while (stim_queue.size() != 0 || req_valid || response_queue.size() != 0);
   endtask

   // Length register is only written once the block has gone idle
   task automatic set_length(input logic [LEN_W-1:0] len);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_now  = len;
      plan_length = len;
      @(negedge clock);
   endtask

   // Writes mostly land inside the shuffled range so shuffles move real data;
   // large ranges get a single shuffle midway to keep the run short
   task automatic random_phase(input logic [LEN_W-1:0] len, input int count);
      int unsigned       span;
      int unsigned       roll;
      logic [ADDR_W-1:0] spot;
      set_length(len);
      span = (len > LEN_W'(DEPTH)) ? DEPTH : 32'(len);
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (span > 64 && k == count / 2) begin
            plan_item(MODE_SHUFFLE, ADDR_W'($urandom()), DATA_W'($urandom()), $urandom());
         end else if (roll < 5) begin
            plan_item(MODE_UNKNOWN, ADDR_W'($urandom()), DATA_W'($urandom()), $urandom());
         end else if (roll < 15 && span <= 64) begin
            plan_item(MODE_SHUFFLE, ADDR_W'($urandom()), DATA_W'($urandom()), $urandom());
         end else if (roll < 55 || !pick_written(span, spot)) begin
            if (span > 0 && $urandom_range(0, 9) < 7)
               spot = ADDR_W'($urandom_range(0, span - 1));
            else
               spot = ADDR_W'($urandom_range(0, DEPTH - 1));
            plan_item(MODE_WRITE, spot, DATA_W'($urandom()), $urandom());
         end else begin
            plan_item(MODE_READ, spot, DATA_W'($urandom()), $urandom());
         end
      end
   endtask

   // Request driver: one item per transfer, random gap after each
   always @(posedge clock) begin : drive_requests
      bit fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) predict_response(offer);
         if (!req_valid || fire) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (stim_queue.size() != 0) begin
               offer = stim_queue.pop_front();
               req_valid    <= 1'b1;
               req_mode     <= offer.mode;
               req_position <= offer.position;
               req_value    <= offer.value;
               req_seed     <= offer.seed;
               if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
               send_gap = send_burst ? 0 : $urandom_range(0, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transfer against the oldest expectation
   always @(posedge clock) begin : watch_responses
      bit           taken;
      response_type want;
      taken = rsp_valid && rsp_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (taken) begin
            results_seen++;
            if (response_queue.size() == 0) begin
               $error("unexpected response: data %h completed %0d", rsp_data, rsp_completed);
               fail_count++;
            end else begin
               want = response_queue.pop_front();
               if (rsp_data !== want.data) begin
                  $error("data: expected %h, got %h", want.data, rsp_data);
                  fail_count++;
               end
               if (rsp_completed !== want.completed) begin
                  $error("completed: expected %0d, got %0d", want.completed, rsp_completed);
                  fail_count++;
               end
            end
            if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
            ready_wait = take_burst ? 0 : $urandom_range(0, 4);
            // long back-pressure so the block fills up and stalls its input
            if (results_seen == 60 || results_seen == 450) ready_wait = HOLD_CYCLES;
         end
         if (ready_wait > 0) begin
            rsp_ready <= 1'b0;
            ready_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_test
      for (int e = 0; e < DEPTH; e++) begin
         entry_copy[1'b0][ADDR_W'(e)] = '0;
         entry_copy[1'b1][ADDR_W'(e)] = '0;
      end
      length_now  = '0;
      plan_length = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // extremes of position and value, read back
      plan_item(MODE_WRITE, 10'h000, 16'hFFFF, 32'h0000_0000);
      plan_item(MODE_WRITE, 10'h3FF, 16'h0000, 32'hFFFF_FFFF);
      plan_item(MODE_WRITE, 10'h2AA, 16'h5555, 32'hAAAA_AAAA);
      plan_item(MODE_WRITE, 10'h155, 16'hAAAA, 32'h5555_5555);
      plan_item(MODE_READ, 10'h000, 16'h0000, 32'h0000_0000);
      plan_item(MODE_READ, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF);
      plan_item(MODE_READ, 10'h2AA, 16'h1234, 32'h0000_0001);
      plan_item(MODE_READ, 10'h155, 16'h4321, 32'h8000_0000);
      // shuffle with length zero swaps nothing
      plan_item(MODE_SHUFFLE, 10'h000, 16'h0000, 32'h0000_0000);
      plan_item(MODE_READ, 10'h000, 16'h0000, 32'h0000_0000);
      // unknown mode leaves the store alone
      plan_item(MODE_UNKNOWN, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF);
      plan_item(MODE_READ, 10'h3FF, 16'h0000, 32'h0000_0000);
      plan_item(MODE_WRITE, 10'h000, 16'h1234, 32'h0000_0000);
      plan_item(MODE_READ, 10'h000, 16'h0000, 32'h0000_0000);

      // length one: still no swap
      set_length(11'd1);
      plan_item(MODE_SHUFFLE, 10'h000, 16'h0000, 32'hFFFF_FFFF);
      plan_item(MODE_READ, 10'h000, 16'h0000, 32'h0000_0000);

      // smallest real shuffle
      set_length(11'd2);
      plan_item(MODE_WRITE, 10'h001, 16'hBEEF, 32'h0000_0000);
      plan_item(MODE_SHUFFLE, 10'h000, 16'h0000, 32'h0000_0001);
      plan_item(MODE_READ, 10'h000, 16'h0000, 32'h0000_0000);
      plan_item(MODE_READ, 10'h001, 16'h0000, 32'h0000_0000);
      plan_item(MODE_SHUFFLE, 10'h000, 16'h0000, 32'h0000_0000);
      plan_item(MODE_READ, 10'h000, 16'h0000, 32'h0000_0000);

      // random phases, including full table and a length past the table
      random_phase(11'd3, 70);
      random_phase(11'd16, 70);
      random_phase(11'd2047, 70);
      random_phase(11'd40, 70);
      random_phase(11'd0, 60);
      random_phase(11'd1024, 70);
      random_phase(11'd7, 70);
      random_phase(11'd2, 60);
      random_phase(11'd5, 70);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
